// ===== rtl/kmct_pkg.sv =====
// shared types and constants of the key matrix change tracker
// used by every module of the block, depends on nothing
package kmct_pkg;

  localparam int KEY_COUNT  = 64;
  localparam int LIST_DEPTH = 16;

  // field widths
  localparam int COL_W  = 3;
  localparam int ROW_W  = 3;
  localparam int RC_W   = 4;
  localparam int KEYF_W = 6;
  localparam int CFG_W  = 6;

  // key index before range check: col * row_count + row
  localparam int RAW_W  = 8;
  localparam int KEY_W  = $clog2(KEY_COUNT);
  localparam int IDX_W  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W  = $clog2(LIST_DEPTH + 1);

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_ROW_COUNT   = 2'd0,
    REG_LEFT_SHIFT  = 2'd1,
    REG_RIGHT_SHIFT = 2'd2,
    REG_SYMBOL      = 2'd3
  } cfg_reg_t;

  localparam logic [RC_W-1:0]   ROW_COUNT_RST   = 4'd7;
  localparam logic [KEYF_W-1:0] LEFT_SHIFT_RST  = 6'd13;
  localparam logic [KEYF_W-1:0] RIGHT_SHIFT_RST = 6'd17;
  localparam logic [KEYF_W-1:0] SYMBOL_RST      = 6'd2;

  typedef struct packed {
    logic [COL_W-1:0] col_index;
    logic [ROW_W-1:0] row_index;
    logic             key_down;
  } sample_t;

  typedef struct packed {
    logic [KEYF_W-1:0] event_key;
    logic              event_pressed;
    logic              shift_held;
    logic              symbol_held;
    logic [KEYF_W-1:0] entry_key;
    logic              entry_valid;
    logic              last_entry;
  } result_t;

  // classified key event handed from front to back
  typedef struct packed {
    logic [KEYF_W-1:0] key;
    logic              down;
    logic              shift;
    logic              symbol;
  } cmd_t;

  typedef struct packed {
    logic             idle;
    logic [CNT_W-1:0] list_count;
  } back_stat_t;

endpackage

// ===== rtl/kmct_front.sv =====
// front end: configuration registers, key index, key bitmap and classification
// depends on kmct_pkg
module kmct_front
  import kmct_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  cfg_reg_t    cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic        accept,
  input  sample_t     sample,
  output logic        cmd_push,
  output cmd_t        cmd
);

  logic [RC_W-1:0]      row_count;
  logic [KEYF_W-1:0]    left_shift_key;
  logic [KEYF_W-1:0]    right_shift_key;
  logic [KEYF_W-1:0]    symbol_key;
  logic [KEY_COUNT-1:0] key_state;
  logic [KEY_COUNT-1:0] key_state_next;

  logic [RAW_W-1:0] key_raw;
  logic             in_range;
  logic             changed;
  logic             is_mod;
  logic             lshift_bit;
  logic             rshift_bit;
  logic             sym_bit;

  assign key_raw = RAW_W'(sample.col_index) * RAW_W'(row_count) + RAW_W'(sample.row_index);
  assign in_range = (RC_W'(sample.row_index) < row_count) && (int'(key_raw) < KEY_COUNT);
  assign changed = in_range && (key_state[key_raw[KEY_W-1:0]] != sample.key_down);
  assign is_mod = (key_raw[KEYF_W-1:0] == left_shift_key) ||
                  (key_raw[KEYF_W-1:0] == right_shift_key) ||
                  (key_raw[KEYF_W-1:0] == symbol_key);

  always_comb begin
    key_state_next = key_state;
    if (accept && changed) begin
      key_state_next[key_raw[KEY_W-1:0]] = sample.key_down;
    end
  end

  // modifier registers outside the key range read as released
  assign lshift_bit = (int'(left_shift_key) < KEY_COUNT) &&
                      key_state_next[left_shift_key[KEY_W-1:0]];
  assign rshift_bit = (int'(right_shift_key) < KEY_COUNT) &&
                      key_state_next[right_shift_key[KEY_W-1:0]];
  assign sym_bit    = (int'(symbol_key) < KEY_COUNT) &&
                      key_state_next[symbol_key[KEY_W-1:0]];

  assign cmd_push   = accept && changed && !is_mod;
  assign cmd.key    = key_raw[KEYF_W-1:0];
  assign cmd.down   = sample.key_down;
  assign cmd.shift  = lshift_bit | rshift_bit;
  assign cmd.symbol = sym_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count       <= ROW_COUNT_RST;
      left_shift_key  <= LEFT_SHIFT_RST;
      right_shift_key <= RIGHT_SHIFT_RST;
      symbol_key      <= SYMBOL_RST;
      key_state       <= '0;
    end else begin
      key_state <= key_state_next;
      if (cfg_valid) begin
        case (cfg_index)
          REG_ROW_COUNT:   row_count       <= cfg_data[RC_W-1:0];
          REG_LEFT_SHIFT:  left_shift_key  <= cfg_data[KEYF_W-1:0];
          REG_RIGHT_SHIFT: right_shift_key <= cfg_data[KEYF_W-1:0];
          REG_SYMBOL:      symbol_key      <= cfg_data[KEYF_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== rtl/kmct_queue.sv =====
// two-entry queue of key events between front and back
// depends on kmct_pkg
module kmct_queue
  import kmct_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t head,
  output logic empty
);

  cmd_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       do_push;
  logic       do_pop;

  assign full    = (fill == 2'd2);
  assign empty   = (fill == 2'd0);
  assign head    = slot[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      if (do_push && !do_pop) begin
        fill <= fill + 2'd1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot[wr_ptr] <= push_data;
  end

endmodule

// ===== rtl/kmct_back.sv =====
// back end: ordered pressed list, run sequencer and result register
// depends on kmct_pkg
module kmct_back
  import kmct_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  input  cmd_t       q_head,
  output logic       q_pop,
  output logic       empty,
  input  logic       pop,
  output result_t    result,
  output back_stat_t stat
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_UPDATE = 3'b010,
    ST_EMIT   = 3'b100
  } state_t;

  state_t            state;
  cmd_t              cur;
  logic [KEYF_W-1:0] list [LIST_DEPTH];
  logic [CNT_W-1:0]  list_count;
  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  run_len;
  logic              out_valid;
  result_t           out_data;
  result_t           emit_data;
  logic              out_load;
  logic              is_last;
  logic              found;
  logic [IDX_W-1:0]  pos;

  // lowest list position holding the current key
  always_comb begin
    found = 1'b0;
    pos   = '0;
    for (int i = LIST_DEPTH - 1; i >= 0; i--) begin
      if ((CNT_W'(i) < list_count) && (list[i] == cur.key)) begin
        found = 1'b1;
        pos   = IDX_W'(i);
      end
    end
  end

  assign run_len = (list_count == '0) ? CNT_W'(1) : list_count;
  assign is_last = (idx == CNT_W'(run_len - CNT_W'(1)));

  always_comb begin
    emit_data.event_key     = cur.key;
    emit_data.event_pressed = cur.down;
    emit_data.shift_held    = cur.shift;
    emit_data.symbol_held   = cur.symbol;
    emit_data.entry_valid   = (list_count != '0);
    emit_data.entry_key     = (list_count != '0) ? list[idx[IDX_W-1:0]] : '0;
    emit_data.last_entry    = is_last;
  end

  assign q_pop    = (state == ST_IDLE) && !q_empty;
  assign out_load = (state == ST_EMIT) && (!out_valid || pop);
  assign empty    = !out_valid;
  assign result   = out_data;
  assign stat.idle       = (state == ST_IDLE);
  assign stat.list_count = list_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      list_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (!q_empty) state <= ST_UPDATE;
        end
        ST_UPDATE: begin
          if (cur.down) begin
            if (!found && (list_count < CNT_W'(LIST_DEPTH))) begin
              list_count <= list_count + CNT_W'(1);
            end
          end else if (found) begin
            list_count <= list_count - CNT_W'(1);
          end
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_load && is_last) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_head;
    if (state == ST_UPDATE) begin
      idx <= '0;
      if (cur.down) begin
        if (!found && (list_count < CNT_W'(LIST_DEPTH))) begin
          list[list_count[IDX_W-1:0]] <= cur.key;
        end
      end else if (found) begin
        // entries after the removed one close up
        for (int i = 0; i < LIST_DEPTH - 1; i++) begin
          if (IDX_W'(i) >= pos) list[i] <= list[i + 1];
        end
      end
    end
    if (out_load) begin
      out_data <= emit_data;
      idx      <= idx + CNT_W'(1);
    end
  end

endmodule

// ===== rtl/key_matrix_change_tracker.sv =====
// Key matrix change tracker. Each sample forms the key index col_index * row_count +
// row_index and updates a key bitmap; a change of a non-modifier key edits the ordered
// pressed list and gives a run of results, one per list entry (or one marked empty).
// The front end takes one sample per cycle into a two-entry event queue while the queue
// is not full; for each event the back end pops it, updates the list, then gives one
// result per list entry. Samples that cause no change, and modifier changes, give no
// result. A result that waits to be popped holds the back end in the middle of a run;
// once the last result of a run sits in the result register, the back end goes on
// with the next event.
// depends on kmct_pkg, kmct_front, kmct_queue, kmct_back
module key_matrix_change_tracker
  import kmct_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  cfg_reg_t         cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             push,
  output logic             full,
  input  sample_t          sample,
  output logic             empty,
  input  logic             pop,
  output result_t          result
);

  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_empty;
  cmd_t       q_in;
  cmd_t       q_head;
  back_stat_t stat;

  assign cfg_ready = 1'b1;
  assign full      = q_full;

  kmct_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (push && !full),
    .sample    (sample),
    .cmd_push  (q_push),
    .cmd       (q_in)
  );

  kmct_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  kmct_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result),
    .stat    (stat)
  );

`ifndef SYNTHESIS
  // the pressed list never grows past its depth
  a_list_bound: assert property (@(posedge clk) disable iff (rst)
    int'(stat.list_count) <= LIST_DEPTH)
    else $error("pressed list count above depth");

  // an empty-list result is always the only one of its run
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && !result.entry_valid) |-> result.last_entry)
    else $error("empty-list result not marked last");

  // front end never offers an event to a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("event queue overflow");

  // the back end leaves idle only by taking a queued event
  a_idle_exit: assert property (@(posedge clk) disable iff (rst)
    (stat.idle && q_empty) |=> stat.idle)
    else $error("back end left idle without an event");
`endif

endmodule
